@@ rtl/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types, character codes and weight tables for the price threshold
// trigger parser.
// ----------------------------------------------------------------------------
package ptt_pkg;

	localparam int FRAC_DIGITS = 4;
	localparam int PRICE_W     = 48;
	localparam int WEIGHT_W    = 24;

	localparam logic [PRICE_W-1:0] PRICE_MAX    = '1;
	localparam logic [PRICE_W-1:0] THRESH_RESET = 48'd1510000;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [2:0] {
		BK_DIGIT,
		BK_DOT,
		BK_SPACE,
		BK_NUL,
		BK_OTHER
	} byte_kind_t;

	typedef struct packed {
		byte_kind_t  kind;
		logic [3:0]  digit;
		logic        last;
	} ptt_cmd_t;

	typedef enum logic [1:0] {
		PH_SEEK,
		PH_PARSE,
		PH_STOP,
		PH_NONE
	} parse_phase_t;

	function automatic logic [WEIGHT_W-1:0] pow10(input logic [2:0] k);
		logic [WEIGHT_W-1:0] w;
		case (k)
			3'd0: w = 24'd1;
			3'd1: w = 24'd10;
			3'd2: w = 24'd100;
			3'd3: w = 24'd1000;
			3'd4: w = 24'd10000;
			3'd5: w = 24'd100000;
			3'd6: w = 24'd1000000;
			3'd7: w = 24'd10000000;
			default: w = 24'd1;
		endcase
		return w;
	endfunction

	// weight of an integer digit, i.e. one whole unit of price in scaled form
	localparam logic [WEIGHT_W-1:0] INT_WEIGHT = pow10(3'(FRAC_DIGITS));

endpackage

@@ rtl/ptt_front.sv @@
// ----------------------------------------------------------------------------
// ptt_front
// Byte classifier and two-entry command queue feeding the parse engine.
// ----------------------------------------------------------------------------
module ptt_front
	import ptt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        cmd_valid,
	output ptt_cmd_t    cmd,
	input  logic        cmd_pop
);

	ptt_cmd_t   cls;
	ptt_cmd_t   cq_mem_q [2];
	logic       cq_wptr_q;
	logic       cq_rptr_q;
	logic [1:0] cq_cnt_q;
	logic       cq_wr;
	logic       cq_rd;

	always_comb begin
		cls.last  = last_byte;
		cls.digit = 4'(data_byte - CH_ZERO);
		if (data_byte >= CH_ZERO && data_byte <= CH_NINE) begin
			cls.kind = BK_DIGIT;
		end else if (data_byte == CH_DOT) begin
			cls.kind = BK_DOT;
		end else if (data_byte == CH_SPACE) begin
			cls.kind = BK_SPACE;
		end else if (data_byte == CH_NUL) begin
			cls.kind = BK_NUL;
		end else begin
			cls.kind = BK_OTHER;
		end
	end

	assign full      = (cq_cnt_q == 2'd2);
	assign cq_wr     = push && !full;
	assign cmd_valid = (cq_cnt_q != 2'd0);
	assign cq_rd     = cmd_pop && cmd_valid;
	assign cmd       = cq_mem_q[cq_rptr_q];

	always_ff @(posedge clk) begin
		if (cq_wr) begin
			cq_mem_q[cq_wptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cq_wptr_q <= 1'b0;
			cq_rptr_q <= 1'b0;
			cq_cnt_q  <= 2'd0;
		end else begin
			if (cq_wr) begin
				cq_wptr_q <= !cq_wptr_q;
			end
			if (cq_rd) begin
				cq_rptr_q <= !cq_rptr_q;
			end
			case ({cq_wr, cq_rd})
				2'b10:   cq_cnt_q <= cq_cnt_q + 2'd1;
				2'b01:   cq_cnt_q <= cq_cnt_q - 2'd1;
				default: cq_cnt_q <= cq_cnt_q;
			endcase
		end
	end

	a_cq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cq_cnt_q != 2'd3)
		else $error("command queue count out of range");

	a_cq_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(cq_cnt_q == 2'd1) |-> (cq_wptr_q != cq_rptr_q))
		else $error("command queue pointers disagree with count");

	// empty or full queue has both pointers on the same slot
	a_cq_ptrs_even: assert property (@(posedge clk) disable iff (!arst_n)
		(cq_cnt_q != 2'd1) |-> (cq_wptr_q == cq_rptr_q))
		else $error("command queue pointers apart on empty or full");

endmodule

@@ rtl/ptt_back.sv @@
// ----------------------------------------------------------------------------
// ptt_back
// Parse engine: phase tracking, fixed point accumulation with saturation,
// and a two-entry result queue with the threshold compare at its head.
// ----------------------------------------------------------------------------
module ptt_back
	import ptt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  ptt_cmd_t           cmd,
	output logic               cmd_pop,
	input  logic [PRICE_W-1:0] thresh,
	output logic               empty,
	input  logic               pop,
	output logic               buy,
	output logic [PRICE_W-1:0] price_scaled,
	output logic               has_price
);

	parse_phase_t       phase_q;
	parse_phase_t       phase_n;
	logic [PRICE_W-1:0] acc_q;
	logic [PRICE_W-1:0] acc_n;
	logic [2:0]         cnt_q;
	logic [2:0]         cnt_n;
	logic               dot_q;
	logic               dot_n;

	logic [PRICE_W+4:0] int_sum;
	logic [PRICE_W:0]   frac_sum;
	logic [2:0]         frac_k;
	logic               frac_room;

	logic [PRICE_W-1:0] rq_price_q [2];
	logic               rq_has_q   [2];
	logic               rq_wptr_q;
	logic               rq_rptr_q;
	logic [1:0]         rq_cnt_q;
	logic               rq_wr;
	logic               rq_rd;
	logic               res_has;

	assign rq_rd   = pop && !empty;
	// a last byte needs a free result slot, other bytes never wait
	assign cmd_pop = cmd_valid && (!cmd.last || rq_cnt_q != 2'd2 || rq_rd);
	assign rq_wr   = cmd_pop && cmd.last;

	assign frac_room = ({1'b0, cnt_q} < 4'(FRAC_DIGITS));
	assign frac_k    = 3'(FRAC_DIGITS - 1 - int'(cnt_q));
	assign int_sum   = ({5'b0, acc_q} << 3) + ({5'b0, acc_q} << 1)
		+ 53'(28'(cmd.digit) * 28'(INT_WEIGHT));
	assign frac_sum  = {1'b0, acc_q} + 49'(28'(cmd.digit) * 28'(pow10(frac_k)));

	// next phase
	always_comb begin
		phase_n = phase_q;
		case (phase_q)
			PH_SEEK: begin
				if (cmd.kind == BK_SPACE) begin
					phase_n = PH_PARSE;
				end else if (cmd.kind == BK_NUL) begin
					phase_n = PH_NONE;
				end
			end
			PH_PARSE: begin
				if (cmd.kind != BK_DIGIT && cmd.kind != BK_DOT) begin
					phase_n = PH_STOP;
				end
			end
			default: phase_n = phase_q;
		endcase
	end

	// accumulator datapath
	always_comb begin
		acc_n = acc_q;
		cnt_n = cnt_q;
		dot_n = dot_q;
		if (phase_q == PH_PARSE) begin
			if (cmd.kind == BK_DOT) begin
				dot_n = 1'b1;
			end else if (cmd.kind == BK_DIGIT) begin
				if (!dot_q) begin
					acc_n = (int_sum[PRICE_W+4:PRICE_W] != 5'd0) ? PRICE_MAX
						: int_sum[PRICE_W-1:0];
				end else if (frac_room) begin
					cnt_n = cnt_q + 3'd1;
					acc_n = frac_sum[PRICE_W] ? PRICE_MAX : frac_sum[PRICE_W-1:0];
				end
			end
		end
	end

	assign res_has = (phase_n == PH_PARSE) || (phase_n == PH_STOP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK;
			acc_q   <= '0;
			cnt_q   <= 3'd0;
			dot_q   <= 1'b0;
		end else if (cmd_pop) begin
			if (cmd.last) begin
				phase_q <= PH_SEEK;
				acc_q   <= '0;
				cnt_q   <= 3'd0;
				dot_q   <= 1'b0;
			end else begin
				phase_q <= phase_n;
				acc_q   <= acc_n;
				cnt_q   <= cnt_n;
				dot_q   <= dot_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rq_wr) begin
			rq_price_q[rq_wptr_q] <= res_has ? acc_n : '0;
			rq_has_q[rq_wptr_q]   <= res_has;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wptr_q <= 1'b0;
			rq_rptr_q <= 1'b0;
			rq_cnt_q  <= 2'd0;
		end else begin
			if (rq_wr) begin
				rq_wptr_q <= !rq_wptr_q;
			end
			if (rq_rd) begin
				rq_rptr_q <= !rq_rptr_q;
			end
			case ({rq_wr, rq_rd})
				2'b10:   rq_cnt_q <= rq_cnt_q + 2'd1;
				2'b01:   rq_cnt_q <= rq_cnt_q - 2'd1;
				default: rq_cnt_q <= rq_cnt_q;
			endcase
		end
	end

	assign empty        = (rq_cnt_q == 2'd0);
	assign price_scaled = rq_price_q[rq_rptr_q];
	assign has_price    = rq_has_q[rq_rptr_q];
	// threshold must only change while idle (unenforced) for the head compare
	assign buy          = has_price && (price_scaled < thresh);

	a_seek_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SEEK || phase_q == PH_NONE) |-> (acc_q == '0 && cnt_q == 3'd0 && !dot_q))
		else $error("accumulator not clear outside a price field");

	a_frac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cnt_q} <= 4'(FRAC_DIGITS)) && (cnt_q == 3'd0 || dot_q))
		else $error("fraction digit count out of range");

	a_rq_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		rq_wr |-> (rq_cnt_q != 2'd2 || rq_rd))
		else $error("result queue overrun");

endmodule

@@ rtl/price_threshold_trigger_parser.sv @@
// ----------------------------------------------------------------------------
// price_threshold_trigger_parser
// Streaming ASCII decimal price parser with a buy threshold trigger.
// ----------------------------------------------------------------------------
// Takes one message byte per cycle. Bytes up to the first space are skipped,
// then an ASCII decimal price is parsed into fixed point with FRAC_DIGITS
// decimal places (extra fraction digits dropped, a second dot ignored,
// saturating at 2^48-1); any other byte or a zero byte stops parsing. On the
// byte flagged last one result item is queued: the price, whether a space was
// found before any zero byte, and buy when the price is below buy_threshold.
// A classifier feeds a two-entry command queue, the parse engine updates its
// accumulator with one multiply-by-ten add and saturation compare per byte,
// and results wait in a two-entry output queue, so a byte is accepted every
// cycle; the input only stalls when both result slots are held and a last
// byte reaches the engine.
// buy_threshold should only be written with no item in flight.
module price_threshold_trigger_parser
	import ptt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	output logic               empty,
	input  logic               pop,
	output logic               buy,
	output logic [PRICE_W-1:0] price_scaled,
	output logic               has_price,
	input  logic               buy_threshold_we,
	input  logic [PRICE_W-1:0] buy_threshold
);

	logic [PRICE_W-1:0] thresh_q;
	logic               cmd_valid;
	ptt_cmd_t           cmd;
	logic               cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (buy_threshold_we) begin
			thresh_q <= buy_threshold;
		end
	end

	ptt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	ptt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.thresh       (thresh_q),
		.empty        (empty),
		.pop          (pop),
		.buy          (buy),
		.price_scaled (price_scaled),
		.has_price    (has_price)
	);

endmodule

@@ tb/price_threshold_trigger_parser_test.sv @@
// ----------------------------------------------------------------------------
// price_threshold_trigger_parser_test
// Self-checking bench for the streaming price parser and buy trigger.
// ----------------------------------------------------------------------------
// Byte messages are pushed through the input queue and every quote popped
// from the output queue is checked against a cycle-free model of the parser.
// The model tracks the parse phase, the scaled price and the fraction digit
// count per message. A short directed run covers some corner cases. Randomized
// messages follow, mostly well formed with random content and some noise,
// over several threshold settings and sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module price_threshold_trigger_parser_test;
	import ptt_pkg::*;

	typedef struct packed {
		logic               buy;
		logic [PRICE_W-1:0] price;
		logic               has_price;
	} quote_t;

	class quote_predictor;
		logic [PRICE_W-1:0] threshold;
		parse_phase_t       phase;
		logic [PRICE_W-1:0] acc;
		int unsigned        frac_count;
		bit                 dot_seen;
		quote_t             pending[$];
		int unsigned        mismatches;
		int unsigned        bytes_seen;
		int unsigned        quotes_seen;
		int unsigned        buys_seen;
		int unsigned        no_price_seen;
		int unsigned        saturated_seen;

		function new();
			threshold      = THRESH_RESET;
			mismatches     = 0;
			bytes_seen     = 0;
			quotes_seen    = 0;
			buys_seen      = 0;
			no_price_seen  = 0;
			saturated_seen = 0;
			clear_message();
		endfunction

		function void clear_message();
			phase      = PH_SEEK;
			acc        = '0;
			frac_count = 0;
			dot_seen   = 1'b0;
		endfunction

		function int unsigned outstanding();
			return pending.size();
		endfunction

		// called for every accepted input item
		function void note_byte(logic [7:0] b, logic is_last);
			logic [63:0] sum;
			logic [63:0] weight;
			bit          has;
			quote_t      q;
			bytes_seen++;
			case (phase)
				PH_SEEK: begin
					if (b == CH_SPACE)
						phase = PH_PARSE;
					else if (b == CH_NUL)
						phase = PH_NONE;
				end
				PH_PARSE: begin
					if (b == CH_DOT) begin
						dot_seen = 1'b1;
					end else if (b >= CH_ZERO && b <= CH_NINE) begin
						weight = 64'd1;
						sum    = 64'(acc);
						if (!dot_seen) begin
							repeat (FRAC_DIGITS) weight = weight * 10;
							sum = 64'(acc) * 10 + 64'(b[3:0]) * weight;
						end else if (frac_count < FRAC_DIGITS) begin
							frac_count++;
							repeat (FRAC_DIGITS - frac_count) weight = weight * 10;
							sum = 64'(acc) + 64'(b[3:0]) * weight;
						end
						acc = (sum > 64'(PRICE_MAX)) ? PRICE_MAX : sum[PRICE_W-1:0];
					end else begin
						phase = PH_STOP;
					end
				end
				default: ;
			endcase
			if (is_last) begin
				has         = (phase == PH_PARSE || phase == PH_STOP);
				q.has_price = has;
				q.price     = has ? acc : '0;
				q.buy       = has && (q.price < threshold);
				pending.push_back(q);
				quotes_seen++;
				if (q.buy)
					buys_seen++;
				if (!has)
					no_price_seen++;
				if (q.price == PRICE_MAX)
					saturated_seen++;
				clear_message();
			end
		endfunction

		function void check_quote(logic b, logic [PRICE_W-1:0] p, logic h);
			quote_t e;
			if (pending.size() == 0) begin
				$error("unexpected quote: buy=%0b price_scaled=%0d has_price=%0b", b, p, h);
				mismatches++;
				return;
			end
			e = pending.pop_front();
			if (b !== e.buy) begin
				$error("buy: expected %0b, actual %0b", e.buy, b);
				mismatches++;
			end
			if (p !== e.price) begin
				$error("price_scaled: expected %0d, actual %0d", e.price, p);
				mismatches++;
			end
			if (h !== e.has_price) begin
				$error("has_price: expected %0b, actual %0b", e.has_price, h);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk              = 1'b0;
	logic               arst_n           = 1'b0;
	logic               push             = 1'b0;
	logic               full;
	logic [7:0]         data_byte        = '0;
	logic               last_byte        = 1'b0;
	logic               empty;
	logic               pop              = 1'b0;
	logic               buy;
	logic [PRICE_W-1:0] price_scaled;
	logic               has_price;
	logic               buy_threshold_we = 1'b0;
	logic [PRICE_W-1:0] buy_threshold    = '0;

	quote_predictor quotes = new();
	logic [7:0]     msg_bytes[$];
	int unsigned    send_idle_pct = 0;
	int unsigned    stall_pct     = 0;
	int unsigned    msg_count     = 0;

	price_threshold_trigger_parser i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.data_byte        (data_byte),
		.last_byte        (last_byte),
		.empty            (empty),
		.pop              (pop),
		.buy              (buy),
		.price_scaled     (price_scaled),
		.has_price        (has_price),
		.buy_threshold_we (buy_threshold_we),
		.buy_threshold    (buy_threshold)
	);

	always #5 clk = ~clk;

	// result side: check what was popped at this edge, then pick the next pop
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				quotes.check_quote(buy, price_scaled, has_price);
			pop <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic is_last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push      <= 1'b1;
		data_byte <= b;
		last_byte <= is_last;
		do @(posedge clk); while (full);
		quotes.note_byte(b, is_last);
	endtask

	task automatic send_message();
		for (int i = 0; i < msg_bytes.size(); i++)
			send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
		msg_count++;
	endtask

	// always lets at least one edge pass so push is not assigned twice
	task automatic drain_quotes();
		push <= 1'b0;
		do @(posedge clk); while (quotes.outstanding() != 0);
	endtask

	task automatic write_threshold(input logic [PRICE_W-1:0] t);
		drain_quotes();
		// let the engine settle after the last popped quote
		repeat (4) @(posedge clk);
		buy_threshold_we <= 1'b1;
		buy_threshold    <= t;
		@(posedge clk);
		buy_threshold_we <= 1'b0;
		quotes.threshold = t;
	endtask

	task automatic push_digits(input int unsigned n);
		repeat (n) msg_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	// mostly "<tag> <int>[.<frac>][<stop><junk>]", with some raw noise
	task automatic compose_message();
		int unsigned n;
		logic [7:0]  c;
		msg_bytes.delete();
		if ($urandom_range(0, 99) < 15) begin
			if ($urandom_range(0, 1))
				msg_bytes.push_back(CH_SPACE);
			repeat ($urandom_range(1, 6)) msg_bytes.push_back(8'($urandom));
			return;
		end
		repeat ($urandom_range(0, 4)) begin
			c = 8'($urandom_range(1, 255));
			msg_bytes.push_back((c == CH_SPACE) ? CH_DOT : c);
		end
		if ($urandom_range(0, 99) < 5)
			msg_bytes.push_back(CH_NUL);
		msg_bytes.push_back(CH_SPACE);
		n = $urandom_range(0, 99);
		if (n < 85)
			push_digits($urandom_range(0, 6));
		else if (n < 95)
			push_digits($urandom_range(11, 16));
		else
			push_digits($urandom_range(7, 10));
		if ($urandom_range(0, 99) < 70) begin
			msg_bytes.push_back(CH_DOT);
			push_digits($urandom_range(0, 7));
			if ($urandom_range(0, 9) == 0) begin
				msg_bytes.push_back(CH_DOT);
				push_digits($urandom_range(0, 3));
			end
		end
		if ($urandom_range(0, 1)) begin
			case ($urandom_range(0, 3))
				0:       msg_bytes.push_back(CH_SPACE);
				1:       msg_bytes.push_back(CH_NUL);
				2:       msg_bytes.push_back(8'h2C);
				default: msg_bytes.push_back(8'($urandom));
			endcase
			repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom));
		end
	endtask

	initial begin
		logic [PRICE_W-1:0] t;
		int unsigned        sent;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, at the reset threshold
		msg_bytes = '{CH_SPACE, CH_ZERO};
		send_message();
		msg_bytes = '{CH_SPACE, 8'h31, 8'h35, 8'h31};                 // equal to threshold
		send_message();
		msg_bytes = '{CH_NUL, CH_SPACE, 8'h35};                       // nul before space
		send_message();
		msg_bytes = '{CH_SPACE, 8'h31, CH_DOT, 8'h32, CH_DOT,
			8'h33, 8'h34, 8'h35, 8'h36, 8'h37};                       // second dot, extra digits
		send_message();
		msg_bytes = '{CH_SPACE};                                      // empty price
		send_message();
		msg_bytes = '{CH_SPACE, CH_NINE, 8'hFF};                      // stop on other byte
		send_message();

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  stall_pct = 0;  t = THRESH_RESET; end
				1: begin send_idle_pct = 82; stall_pct = 0;  t = '0; end
				2: begin send_idle_pct = 0;  stall_pct = 82; t = PRICE_MAX; end
				3: begin
					send_idle_pct = 20;
					stall_pct     = 20;
					t = {16'($urandom_range(0, 3)), 32'($urandom)};
				end
				default: begin
					send_idle_pct = 0;
					stall_pct     = 0;
					t = {16'($urandom), 32'($urandom)};
				end
			endcase
			write_threshold(t);
			sent = 0;
			while (sent < 100) begin
				// hold off until the output side has caught up
				if (msg_count % 9 == 4)
					drain_quotes();
				compose_message();
				send_message();
				sent += msg_bytes.size();
			end
		end

		drain_quotes();
		repeat (8) @(posedge clk);
		$display("covered %0d messages, %0d bytes, %0d quotes (%0d buy, %0d without price,",
			msg_count, quotes.bytes_seen, quotes.quotes_seen, quotes.buys_seen,
			quotes.no_price_seen);
		$display("  %0d saturated) over five threshold settings and idling mixes",
			quotes.saturated_seen);
		if (quotes.mismatches == 0 && quotes.outstanding() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#3000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
